>>> hdl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the first condition holds, the second holds at the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// When the first condition holds, the second holds at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ps2mt_pkg.sv
// Package for the PS/2 mouse packet tracker: widths, reset values, codes and types.
// Used by the channel interfaces and by every tracker module.
package ps2mt_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ACC_BITS    = 32;
  localparam int BYTE_W      = 8;
  localparam int CFG_COORD_W = 12;
  localparam int LIMIT_W     = 8;
  localparam int DELTA_W     = 9;
  localparam int BTN_W       = 3;
  localparam int OUT_COORD_W = 12;
  localparam int OUT_ACC_W   = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int TOP_W       = (COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W;
  localparam int CMP_W       = TOP_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int HDR_BTN_MSB   = 2;
  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;
  localparam int HDR_XOVF_BIT  = 6;
  localparam int HDR_YOVF_BIT  = 7;

  localparam logic [CFG_COORD_W-1:0] X_MAX_RST       = CFG_COORD_W'(1023);
  localparam logic [CFG_COORD_W-1:0] Y_MAX_RST       = CFG_COORD_W'(767);
  localparam logic [LIMIT_W-1:0]     DELTA_LIMIT_RST = LIMIT_W'(64);
  localparam logic [COORD_BITS-1:0]  POS_X_RST       = COORD_BITS'(400);
  localparam logic [COORD_BITS-1:0]  POS_Y_RST       = COORD_BITS'(300);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_XBYTE,
    PH_YBYTE
  } phase_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_SKIP,
    CMD_DROP,
    CMD_MOVE
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MAX       = 2'd0,
    REG_Y_MAX       = 2'd1,
    REG_DELTA_LIMIT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_COORD_W-1:0] x_max;
    logic [CFG_COORD_W-1:0] y_max;
    logic [LIMIT_W-1:0]     delta_limit;
  } cfg_t;

  typedef struct packed {
    cmd_e                      kind;
    logic [BTN_W-1:0]          buttons;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } cmd_t;

endpackage

>>> hdl/ps2mt_ifs.sv
// Valid/ready channel interfaces of the tracker: byte input, configuration and result.
// Depends on ps2mt_pkg for the field widths.
interface ps2mt_in_if;
  import ps2mt_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ps2mt_cfg_if;
  import ps2mt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

interface ps2mt_out_if;
  import ps2mt_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OUT_COORD_W-1:0]      cursor_x;
  logic [OUT_COORD_W-1:0]      cursor_y;
  logic [BTN_W-1:0]            button_bits;
  logic signed [OUT_ACC_W-1:0] total_dx;
  logic signed [OUT_ACC_W-1:0] total_dy;
  logic                        packet_done;
  logic                        motion_dropped;
  logic                        sync_skip;
  modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                  output total_dx, output total_dy, output packet_done,
                  output motion_dropped, output sync_skip, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input button_bits,
                input total_dx, input total_dy, input packet_done,
                input motion_dropped, input sync_skip, output ready);
endinterface

>>> hdl/ps2_mouse_packet_tracker_top.sv
// Path: an accepted byte's command is written into the queue, then popped into the
// result register that drives the output channel. Throughput: one byte per cycle
// while out_ch_o is ready; the back end adds and clamps combinationally. The two-entry
// queue and the result register let input and output stall on their own.
// Reset is asynchronous and active low: control registers return to their defaults and
// the cursor to (400, 300) at once, with no clearing pass; result flags and queue
// storage are not reset. Configuration writes take effect in the next cycle.
module ps2_mouse_packet_tracker_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  ps2mt_in_if.sink     in_ch_i,
  ps2mt_cfg_if.sink    cfg_ch_i,
  ps2mt_out_if.source  out_ch_o
);
  import ps2mt_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  assign cfg_ch_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_ch_i.valid) begin
      case (cfg_ch_i.reg_index)
        REG_X_MAX:       cfg_d.x_max       = cfg_ch_i.wdata[CFG_COORD_W-1:0];
        REG_Y_MAX:       cfg_d.y_max       = cfg_ch_i.wdata[CFG_COORD_W-1:0];
        REG_DELTA_LIMIT: cfg_d.delta_limit = cfg_ch_i.wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{x_max: X_MAX_RST, y_max: Y_MAX_RST, delta_limit: DELTA_LIMIT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ps2mt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  ps2mt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  ps2mt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .out_ch_o  (out_ch_o)
  );

endmodule

>>> hdl/ps2mt_front.sv
// Front end: accepts mouse bytes, tracks the packet phase and classifies each item.
// Emits one command per item, with clamped deltas, into the queue. Uses ps2mt_pkg.
module ps2mt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ps2mt_in_if.sink          in_ch_i,
  input  ps2mt_pkg::cfg_t   cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output ps2mt_pkg::cmd_t   cmd_o
);
  import ps2mt_pkg::*;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] header_q, header_d;
  logic [BYTE_W-1:0] xbyte_q, xbyte_d;
  logic              accept;
  logic              overflow;
  logic signed [DELTA_W-1:0] dx_raw;
  logic signed [DELTA_W:0]   dy_raw;
  logic signed [DELTA_W:0]   dx_wide;
  logic signed [DELTA_W:0]   dy_neg;

  function automatic logic signed [DELTA_W-1:0] clamp_delta(
    input logic signed [DELTA_W:0] d,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [DELTA_W:0] lim_s;
    logic signed [DELTA_W:0] r;
    lim_s = $signed((DELTA_W + 1)'(lim));
    r = d;
    if (d > lim_s) begin
      r = lim_s;
    end else if (d < -lim_s) begin
      r = -lim_s;
    end
    return r[DELTA_W-1:0];
  endfunction

  assign in_ch_i.ready = !q_full_i;
  assign accept = in_ch_i.valid && !q_full_i;
  assign push_o = accept;

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    xbyte_d  = xbyte_q;
    if (accept) begin
      case (phase_q)
        PH_XBYTE: begin
          xbyte_d = in_ch_i.data_byte;
          phase_d = PH_YBYTE;
        end
        PH_YBYTE: begin
          phase_d = PH_HEADER;
        end
        default: begin
          if (in_ch_i.data_byte[HDR_SYNC_BIT]) begin
            header_d = in_ch_i.data_byte;
            phase_d  = PH_XBYTE;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      endcase
    end
  end

  assign overflow = header_q[HDR_XOVF_BIT] | header_q[HDR_YOVF_BIT];
  assign dx_raw   = $signed({header_q[HDR_XSIGN_BIT], xbyte_q});
  assign dy_raw   = $signed({header_q[HDR_YSIGN_BIT], header_q[HDR_YSIGN_BIT],
                             in_ch_i.data_byte});
  assign dx_wide  = $signed({dx_raw[DELTA_W-1], dx_raw});
  assign dy_neg   = -dy_raw;

  always_comb begin
    cmd_o.buttons = header_q[HDR_BTN_MSB:0];
    cmd_o.dx      = clamp_delta(dx_wide, cfg_i.delta_limit);
    cmd_o.dy      = clamp_delta(dy_neg, cfg_i.delta_limit);
    case (phase_q)
      PH_XBYTE: cmd_o.kind = CMD_HOLD;
      PH_YBYTE: cmd_o.kind = overflow ? CMD_DROP : CMD_MOVE;
      default:  cmd_o.kind = in_ch_i.data_byte[HDR_SYNC_BIT] ? CMD_HOLD : CMD_SKIP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      header_q <= '0;
      xbyte_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      header_q <= header_d;
      xbyte_q  <= xbyte_d;
    end
  end

endmodule

>>> hdl/ps2mt_queue.sv
// Two-entry command queue between the front end and the back end.
// Holds ps2mt_pkg::cmd_t items so each side can stall on its own.
`include "assert_macros.svh"

module ps2mt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ps2mt_pkg::cmd_t push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output ps2mt_pkg::cmd_t pop_cmd_o,
  output logic            empty_o
);
  import ps2mt_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  function automatic logic [QUEUE_PTR_W-1:0] next_ptr(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o    = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_q <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overrun")
  `ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o, "pop from an empty queue")
  `ASSERT_NEXT(a_push_counts, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

>>> hdl/ps2mt_back.sv
// Back end: executes queued commands on the cursor, buttons and accumulators.
// Holds the result register of the output channel. Uses ps2mt_pkg and the macros.
`include "assert_macros.svh"

module ps2mt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ps2mt_pkg::cfg_t cfg_i,
  input  logic            q_empty_i,
  input  ps2mt_pkg::cmd_t cmd_i,
  output logic            pop_o,
  ps2mt_out_if.source     out_ch_o
);
  import ps2mt_pkg::*;

  localparam logic [TOP_W-1:0] COORD_MAX = TOP_W'((1 << COORD_BITS) - 1);

  logic [COORD_BITS-1:0]      pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0]      pos_y_q, pos_y_d;
  logic [BTN_W-1:0]           btn_q, btn_d;
  logic signed [ACC_BITS-1:0] acc_dx_q, acc_dx_d;
  logic signed [ACC_BITS-1:0] acc_dy_q, acc_dy_d;
  logic                       valid_q, valid_d;
  logic                       done_q, done_d;
  logic                       drop_q, drop_d;
  logic                       skip_q, skip_d;
  logic [TOP_W-1:0]           top_x;
  logic [TOP_W-1:0]           top_y;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] acc,
    input logic signed [DELTA_W-1:0]  d
  );
    logic signed [ACC_BITS:0] sum;
    logic signed [ACC_BITS-1:0] r;
    sum = $signed({acc[ACC_BITS-1], acc}) + $signed((ACC_BITS + 1)'(d));
    r = sum[ACC_BITS-1:0];
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      r = sum[ACC_BITS] ? $signed({1'b1, {(ACC_BITS - 1){1'b0}}})
                        : $signed({1'b0, {(ACC_BITS - 1){1'b1}}});
    end
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] move_coord(
    input logic [COORD_BITS-1:0]     pos,
    input logic signed [DELTA_W-1:0] d,
    input logic [TOP_W-1:0]          top
  );
    logic signed [CMP_W-1:0] p;
    logic signed [CMP_W-1:0] top_s;
    logic signed [CMP_W-1:0] r;
    p     = $signed(CMP_W'(pos)) + $signed(CMP_W'(d));
    top_s = $signed(CMP_W'(top));
    r     = p;
    if (p < 0) begin
      r = '0;
    end else if (p > top_s) begin
      r = top_s;
    end
    return r[COORD_BITS-1:0];
  endfunction

  assign top_x = (TOP_W'(cfg_i.x_max) < COORD_MAX) ? TOP_W'(cfg_i.x_max) : COORD_MAX;
  assign top_y = (TOP_W'(cfg_i.y_max) < COORD_MAX) ? TOP_W'(cfg_i.y_max) : COORD_MAX;

  assign pop_o = !q_empty_i && (!valid_q || out_ch_o.ready);

  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    btn_d    = btn_q;
    acc_dx_d = acc_dx_q;
    acc_dy_d = acc_dy_q;
    done_d   = done_q;
    drop_d   = drop_q;
    skip_d   = skip_q;
    valid_d  = valid_q && !out_ch_o.ready;
    if (pop_o) begin
      valid_d = 1'b1;
      done_d  = (cmd_i.kind == CMD_MOVE) || (cmd_i.kind == CMD_DROP);
      drop_d  = (cmd_i.kind == CMD_DROP);
      skip_d  = (cmd_i.kind == CMD_SKIP);
      case (cmd_i.kind)
        CMD_MOVE: begin
          btn_d    = cmd_i.buttons;
          acc_dx_d = sat_add(acc_dx_q, cmd_i.dx);
          acc_dy_d = sat_add(acc_dy_q, cmd_i.dy);
          pos_x_d  = move_coord(pos_x_q, cmd_i.dx, top_x);
          pos_y_d  = move_coord(pos_y_q, cmd_i.dy, top_y);
        end
        CMD_DROP: begin
          btn_d = cmd_i.buttons;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= POS_X_RST;
      pos_y_q  <= POS_Y_RST;
      btn_q    <= '0;
      acc_dx_q <= '0;
      acc_dy_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      btn_q    <= btn_d;
      acc_dx_q <= acc_dx_d;
      acc_dy_q <= acc_dy_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d;
    drop_q <= drop_d;
    skip_q <= skip_d;
  end

  assign out_ch_o.valid          = valid_q;
  assign out_ch_o.cursor_x       = OUT_COORD_W'(pos_x_q);
  assign out_ch_o.cursor_y       = OUT_COORD_W'(pos_y_q);
  assign out_ch_o.button_bits    = btn_q;
  assign out_ch_o.total_dx       = OUT_ACC_W'(acc_dx_q);
  assign out_ch_o.total_dy       = OUT_ACC_W'(acc_dy_q);
  assign out_ch_o.packet_done    = done_q;
  assign out_ch_o.motion_dropped = drop_q;
  assign out_ch_o.sync_skip      = skip_q;

  `ASSERT_IMPL(a_drop_has_done, valid_q && drop_q, done_q && !skip_q, "dropped without done")
  `ASSERT_NEXT(a_cursor_bound, pop_o && cmd_i.kind == CMD_MOVE,
               TOP_W'(pos_x_q) <= top_x && TOP_W'(pos_y_q) <= top_y, "cursor out of bound")
  `ASSERT_NEXT(a_hold_keeps, pop_o && (cmd_i.kind == CMD_HOLD || cmd_i.kind == CMD_SKIP),
               $stable(acc_dx_q) && $stable(acc_dy_q) && $stable(pos_x_q), "state moved")

endmodule
